FILE: rtl/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

    // Width of every operand and result word.
    localparam int WORD_W = 32;

    // Saturation codes for the quotient.
    localparam logic [WORD_W-1:0] QUO_MOST_NEG = 32'h8000_0000;
    localparam logic [WORD_W-1:0] QUO_MOST_POS = 32'h7FFF_FFFF;

    // One input beat.
    typedef struct packed {
        logic signed [WORD_W-1:0] dividend;
        logic signed [WORD_W-1:0] divisor;
    } sfd_in_t;

    // One result beat.
    typedef struct packed {
        logic signed [WORD_W-1:0] quotient;
        logic                     saturated;
    } sfd_out_t;

    // Control bits that travel down the pipeline with each beat.
    typedef struct packed {
        logic valid;
        logic sat;
        logic differ;
    } sfd_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/saturating_fixed_divide_16_16.sv
// Path: a beat accepted at a clock edge passes through the front end, one divider stage
// per quotient bit and the back end's output register before it is strobed on result.
// Throughput: one beat per cycle once busy is low; the restoring divider has one
// register stage per quotient bit, so the pipeline depth sets the latency and nothing limits the rate.
// Reset: rst_n clears every valid bit at once; busy is high during reset and for
// the first cycle after it, then stays low, since the receiver cannot stall results.
`default_nettype none

module saturating_fixed_divide_16_16 #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire sfd_pkg::sfd_in_t      operands,
    output logic                       result_valid,
    output sfd_pkg::sfd_out_t          result
);
    import sfd_pkg::*;

    // With the overflow guard passed, the quotient is known to fit in
    // 2*FRACTION_BITS-1 bits, so the divider needs only that many steps.
    localparam int QUO_BITS = 2 * FRACTION_BITS - 1;

    // Two front stages, one stage per quotient bit, one output stage.
    localparam int LATENCY = QUO_BITS + 3;

    // Ready comes up in the cycle after reset is released and stays up.
    logic ready_reg;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
        end
    end

    assign busy   = ~ready_reg;
    assign accept = start & ~busy;

    // Pipeline buses: index k is the input of divider step k, index
    // QUO_BITS is the output of the last step.
    sfd_ctl_t            ctl_s [0:QUO_BITS];
    logic [WORD_W-1:0]   rem_s [0:QUO_BITS];
    logic [WORD_W-1:0]   mb_s  [0:QUO_BITS];
    logic [QUO_BITS-1:0] num_s [0:QUO_BITS];
    logic [QUO_BITS-1:0] quo_s [0:QUO_BITS];

    // The front end forms the operand magnitudes and the result sign,
    // then runs the overflow guard and loads the partial remainder with
    // the high bits of the shifted dividend magnitude.
    sfd_front #(
        .FRACTION_BITS (FRACTION_BITS),
        .QUO_BITS      (QUO_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .operands (operands),
        .ctl_out  (ctl_s[0]),
        .rem_out  (rem_s[0]),
        .mb_out   (mb_s[0]),
        .num_out  (num_s[0])
    );

    assign quo_s[0] = '0;

    // Each divider step produces one quotient bit, most significant
    // first. Saturated beats flow through unchanged in timing; their
    // quotient bits are ignored at the output.
    generate
        for (genvar k = 0; k < QUO_BITS; k++)
        begin : g_step
            sfd_div_stage #(
                .QUO_BITS (QUO_BITS)
            ) u_step (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl_in  (ctl_s[k]),
                .rem_in  (rem_s[k]),
                .mb_in   (mb_s[k]),
                .num_in  (num_s[k]),
                .quo_in  (quo_s[k]),
                .ctl_out (ctl_s[k+1]),
                .rem_out (rem_s[k+1]),
                .mb_out  (mb_s[k+1]),
                .num_out (num_s[k+1]),
                .quo_out (quo_s[k+1])
            );
        end
    endgenerate

    // The back end applies the sign or substitutes the saturation code
    // and registers the result beat for its single strobe cycle.
    sfd_back #(
        .QUO_BITS (QUO_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_in       (ctl_s[QUO_BITS]),
        .quo_in       (quo_s[QUO_BITS]),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // Every accepted beat comes out on result_valid once it has passed the whole pipeline.
    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY result_valid)
        else $error("accepted beat did not produce a result");

    // No result appears without a beat accepted the whole pipeline depth before.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, LATENCY))
        else $error("result strobe without an accepted beat");
`endif

endmodule

`default_nettype wire

FILE: rtl/sfd_front.sv
`default_nettype none

module sfd_front #(
    parameter int FRACTION_BITS = 16,
    parameter int QUO_BITS      = 2 * FRACTION_BITS - 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire sfd_pkg::sfd_in_t      operands,
    output sfd_pkg::sfd_ctl_t          ctl_out,
    output logic [31:0]                rem_out,
    output logic [31:0]                mb_out,
    output logic [QUO_BITS-1:0]        num_out
);
    import sfd_pkg::*;

    localparam int NUM_W = WORD_W + FRACTION_BITS;

    // Stage 1: operand magnitudes and result sign.
    sfd_ctl_t          ctl1_reg;
    sfd_ctl_t          ctl1_next;
    logic [WORD_W-1:0] ma_reg;
    logic [WORD_W-1:0] ma_next;
    logic [WORD_W-1:0] mb1_reg;
    logic [WORD_W-1:0] mb1_next;

    // Stage 2: overflow guard and divider setup.
    sfd_ctl_t          ctl2_reg;
    sfd_ctl_t          ctl2_next;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] mb2_reg;
    logic [QUO_BITS-1:0] num_reg;
    logic [QUO_BITS-1:0] num_next;

    logic [WORD_W:0]   guard_lhs;
    logic [NUM_W-1:0]  num_full;

    // The magnitude of the most negative word wraps to itself, which is
    // exactly 2^31 when read as unsigned.
    always_comb
    begin
        ma_next  = operands.dividend[WORD_W-1] ? (~operands.dividend + 32'd1)
                                                : operands.dividend;
        mb1_next = operands.divisor[WORD_W-1] ? (~operands.divisor + 32'd1)
                                               : operands.divisor;
        ctl1_next.valid  = accept;
        ctl1_next.sat    = 1'b0;
        ctl1_next.differ = operands.dividend[WORD_W-1] ^ operands.divisor[WORD_W-1];
    end

    generate
        if (FRACTION_BITS >= 2)
        begin : g_guard_shr
            assign guard_lhs = {1'b0, ma_reg >> (FRACTION_BITS - 2)};
        end
        else
        begin : g_guard_shl
            assign guard_lhs = {ma_reg, 1'b0};
        end
    endgenerate

    // The guard bounds the quotient below 2^QUO_BITS, so the partial
    // remainder may start from the bits above the low QUO_BITS of the
    // shifted dividend.
    always_comb
    begin
        num_full         = {ma_reg, {FRACTION_BITS{1'b0}}};
        num_next         = num_full[QUO_BITS-1:0];
        rem_next         = WORD_W'(num_full >> QUO_BITS);
        ctl2_next.valid  = ctl1_reg.valid;
        ctl2_next.sat    = guard_lhs >= {1'b0, mb1_reg};
        ctl2_next.differ = ctl1_reg.differ;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb1_reg <= mb1_next;
        rem_reg <= rem_next;
        mb2_reg <= mb1_reg;
        num_reg <= num_next;
    end

    assign ctl_out = ctl2_reg;
    assign rem_out = rem_reg;
    assign mb_out  = mb2_reg;
    assign num_out = num_reg;

`ifndef ASSERT_OFF
    // A zero divisor must always take the saturating path.
    a_zero_divisor_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ctl2_reg.valid && (mb2_reg == '0) |-> ctl2_reg.sat)
        else $error("zero divisor did not saturate");
`endif

endmodule

`default_nettype wire

FILE: rtl/sfd_div_stage.sv
`default_nettype none

module sfd_div_stage #(
    parameter int QUO_BITS = 31
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sfd_pkg::sfd_ctl_t     ctl_in,
    input  wire logic [31:0]           rem_in,
    input  wire logic [31:0]           mb_in,
    input  wire logic [QUO_BITS-1:0]   num_in,
    input  wire logic [QUO_BITS-1:0]   quo_in,
    output sfd_pkg::sfd_ctl_t          ctl_out,
    output logic [31:0]                rem_out,
    output logic [31:0]                mb_out,
    output logic [QUO_BITS-1:0]        num_out,
    output logic [QUO_BITS-1:0]        quo_out
);
    import sfd_pkg::*;

    sfd_ctl_t            ctl_reg;
    logic [WORD_W-1:0]   rem_reg;
    logic [WORD_W-1:0]   rem_next;
    logic [WORD_W-1:0]   mb_reg;
    logic [QUO_BITS-1:0] num_reg;
    logic [QUO_BITS-1:0] num_next;
    logic [QUO_BITS-1:0] quo_reg;
    logic [QUO_BITS-1:0] quo_next;

    logic [WORD_W:0]     trial;
    logic [WORD_W+1:0]   diff;
    logic                take;

    // One restoring step: bring down the next dividend bit and subtract
    // the divisor if it fits.
    always_comb
    begin
        trial    = {rem_in, num_in[QUO_BITS-1]};
        diff     = {1'b0, trial} - {2'b00, mb_in};
        take     = ~diff[WORD_W+1];
        rem_next = take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        num_next = num_in << 1;
        quo_next = (quo_in << 1) | QUO_BITS'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        mb_reg  <= mb_in;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign mb_out  = mb_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;

`ifndef ASSERT_OFF
    // On the dividing path the partial remainder stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid && !ctl_reg.sat |-> rem_reg < mb_reg)
        else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: rtl/sfd_back.sv
`default_nettype none

module sfd_back #(
    parameter int QUO_BITS = 31
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sfd_pkg::sfd_ctl_t     ctl_in,
    input  wire logic [QUO_BITS-1:0]   quo_in,
    output logic                       result_valid,
    output sfd_pkg::sfd_out_t          result
);
    import sfd_pkg::*;

    localparam int QUO_W = (QUO_BITS > WORD_W) ? QUO_BITS : WORD_W;

    logic              valid_reg;
    sfd_out_t          result_reg;
    sfd_out_t          result_next;
    logic [QUO_W-1:0]  quo_wide;
    logic [WORD_W-1:0] mag;

    // Wide settings keep only the low word of the quotient.
    always_comb
    begin
        quo_wide = QUO_W'(quo_in);
        mag      = quo_wide[WORD_W-1:0];
        if (ctl_in.sat)
        begin
            result_next.quotient = ctl_in.differ ? $signed(QUO_MOST_NEG)
                                                 : $signed(QUO_MOST_POS);
        end
        else
        begin
            result_next.quotient = ctl_in.differ ? $signed(~mag + 32'd1) : $signed(mag);
        end
        result_next.saturated = ctl_in.sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // A saturated beat carries one of the two extreme codes.
    a_sat_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.quotient == $signed(QUO_MOST_NEG)) ||
            (result.quotient == $signed(QUO_MOST_POS)))
        else $error("saturated quotient is not an extreme code");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/sfd_quotient_checker.sv
`default_nettype none

// Scoreboard for the saturating divider. It sees every accepted operand beat,
// works out the quotient it should produce, and checks each result strobe
// against the oldest outstanding quotient.
module sfd_quotient_checker
    import sfd_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     busy,
    input  wire sfd_in_t  operands,
    input  wire logic     result_valid,
    input  wire sfd_out_t result,
    output int            mismatches,
    output int            in_flight
);

    sfd_out_t pending_quotients[$];

    // Exact 33-bit magnitude, so the most negative word maps to 2^31.
    function automatic logic [WORD_W:0] magnitude(logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? ((WORD_W+1)'(0) - {1'b1, v}) : {1'b0, v};
    endfunction

    function automatic sfd_out_t divide_fixed(sfd_in_t b);
        logic [WORD_W:0]   mag_num;
        logic [WORD_W:0]   mag_den;
        logic [63:0]       wide;
        logic              differ;
        sfd_out_t          q;
        mag_num = magnitude(b.dividend);
        mag_den = magnitude(b.divisor);
        differ  = b.dividend[WORD_W-1] ^ b.divisor[WORD_W-1];
        if ((mag_num >> (FRACTION_BITS - 2)) >= mag_den)
        begin
            q.quotient  = differ ? QUO_MOST_NEG : QUO_MOST_POS;
            q.saturated = 1'b1;
        end
        else
        begin
            wide        = (64'(mag_num) << FRACTION_BITS) / 64'(mag_den);
            q.quotient  = differ ? (~wide[WORD_W-1:0] + 1'b1) : wide[WORD_W-1:0];
            q.saturated = 1'b0;
        end
        return q;
    endfunction

    always @(posedge clk)
    begin
        sfd_out_t want;
        if (rst_n)
        begin
            if (start && !busy)
                pending_quotients.push_back(divide_fixed(operands));
            if (result_valid)
            begin
                if (pending_quotients.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing outstanding: q=%h sat=%b",
                                 $realtime, result.quotient, result.saturated);
                end
                else
                begin
                    want = pending_quotients.pop_front();
                    if (result.quotient !== want.quotient ||
                        result.saturated !== want.saturated)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected q=%h sat=%b, got q=%h sat=%b",
                                     $realtime, want.quotient, want.saturated,
                                     result.quotient, result.saturated);
                    end
                end
            end
            in_flight <= pending_quotients.size();
        end
        else
        begin
            pending_quotients.delete();
            mismatches = 0;
            in_flight  <= 0;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none

// Top of the divider regression. This module only generates operand beats and
// gives the verdict; all prediction and comparison happens in the checker
// that sits beside the divider and watches both of its channels.
module testbench;
    import sfd_pkg::*;

    localparam int FRACTION_BITS = 16;
    // Depth of the divider pipeline, from acceptance to result strobe.
    localparam int PIPE_DEPTH    = 2 * FRACTION_BITS + 2;
    localparam int RANDOM_BEATS  = 1300;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    sfd_in_t  operands = '0;
    logic     result_valid;
    sfd_out_t result;
    int       mismatches;
    int       in_flight;

    // Half-period of five time units gives a ten-unit clock.
    always #5 clk = ~clk;

    saturating_fixed_divide_16_16 #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operands     (operands),
        .result_valid (result_valid),
        .result       (result)
    );

    sfd_quotient_checker #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operands     (operands),
        .result_valid (result_valid),
        .result       (result),
        .mismatches   (mismatches),
        .in_flight    (in_flight)
    );

    // Present one beat at the falling edge and hold it until a rising edge
    // sees busy low. The divider accepts on that edge, and the checker sees
    // the very same sample, so both agree on which beats went in.
    task automatic send_beat(input logic [WORD_W-1:0] num, input logic [WORD_W-1:0] den);
        @(negedge clk);
        start    <= 1'b1;
        operands <= '{dividend: num, divisor: den};
        do
            @(posedge clk);
        while (busy);
    endtask

    // Idle the sender. The operand bus carries junk while start is low, which
    // the divider must ignore.
    task automatic rest();
        @(negedge clk);
        start    <= 1'b0;
        operands <= '{dividend: $urandom, divisor: $urandom};
    endtask

    // Apply a sign to a magnitude of up to 2^31; the result wraps to 32 bits.
    function automatic logic [WORD_W-1:0] signed_word(logic [WORD_W:0] mag, logic neg);
        return neg ? WORD_W'((WORD_W+1)'(0) - mag) : mag[WORD_W-1:0];
    endfunction

    // Random operand pairs. The mix is chosen so that both saturated and
    // ordinary quotients come up often, and so that the overflow guard is hit
    // right at its boundary, where an off-by-one would hide.
    task automatic send_random();
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
        logic [WORD_W:0]   mag_den;
        logic [WORD_W:0]   mag_num;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            // Raw words: every bit of both fields toggles here.
            num = $urandom;
            den = $urandom;
        end
        else if (pick < 45)
        begin
            // Small divisors push about half of these into saturation.
            num = $urandom;
            den = signed_word((WORD_W+1)'($urandom_range(1, 1 << 17)),
                              1'($urandom_range(1)));
        end
        else if (pick < 65)
        begin
            // Dividend magnitude within two counts of the guard threshold.
            mag_den = (WORD_W+1)'($urandom_range(1, 131071));
            mag_num = (mag_den << (FRACTION_BITS - 2))
                      + (WORD_W+1)'($urandom_range(4)) - (WORD_W+1)'(2);
            num     = signed_word(mag_num, 1'($urandom_range(1)));
            den     = signed_word(mag_den, 1'($urandom_range(1)));
        end
        else if (pick < 75)
        begin
            // Corner divisors: zero, one, minus one and both extremes.
            case ($urandom_range(4))
                0: den = '0;
                1: den = 32'sd1;
                2: den = '1;
                3: den = QUO_MOST_NEG;
                default: den = QUO_MOST_POS;
            endcase
            case ($urandom_range(3))
                0: num = QUO_MOST_NEG;
                1: num = QUO_MOST_POS;
                2: num = '0;
                default: num = $urandom;
            endcase
        end
        else
        begin
            // Everyday 16.16 values, which mostly give ordinary quotients.
            num = signed_word((WORD_W+1)'($urandom_range(0, 1 << 20)),
                              1'($urandom_range(1)));
            den = signed_word((WORD_W+1)'($urandom_range(1, 1 << 24)),
                              1'($urandom_range(1)));
        end
        send_beat(num, den);
    endtask

    // Hold the sender off until every outstanding quotient has come back.
    task automatic drain();
        rest();
        while (in_flight != 0)
            rest();
    endtask

    initial
    begin
        int idle_pct[4];
        idle_pct = '{0, 51, 8, 0};

        // Hold reset, then release it at a falling edge, away from the
        // sampling edge. Busy covers the cycle after release.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats: zero divisor with both dividend signs, the most
        // negative word as either operand, unit divisors, the exact guard boundary
        // on each side for a positive divisor, and just below it in each sign quadrant.
        send_beat(32'sd0,          32'sd0);
        send_beat(32'sd1,          32'sd0);
        send_beat(-32'sd1,         32'sd0);
        send_beat(QUO_MOST_NEG,    32'sd0);
        send_beat(QUO_MOST_POS,    32'sd0);
        send_beat(QUO_MOST_NEG,    QUO_MOST_NEG);
        send_beat(QUO_MOST_NEG,    QUO_MOST_POS);
        send_beat(QUO_MOST_POS,    QUO_MOST_NEG);
        send_beat(QUO_MOST_POS,    QUO_MOST_POS);
        send_beat(QUO_MOST_NEG,    32'sd1);
        send_beat(QUO_MOST_POS,    -32'sd1);
        send_beat(32'sd0,          32'sd1);
        send_beat(32'sd0,          -32'sd1);
        send_beat(32'sd0,          QUO_MOST_NEG);
        send_beat(32'sd65536,      32'sd65536);
        send_beat(-32'sd65536,     32'sd196608);
        send_beat(32'sd81920,      32'sd5);
        send_beat(32'sd81919,      32'sd5);
        send_beat(-32'sd81920,     32'sd5);
        send_beat(-32'sd81919,     32'sd5);
        send_beat(32'sd81919,      -32'sd5);
        send_beat(-32'sd81919,     -32'sd5);
        send_beat(32'sd1,          QUO_MOST_NEG);
        send_beat(-32'sd1,         QUO_MOST_POS);

        // Random part in four phases: back to back, sender idle about half
        // the time, sender idle now and then, and back to back again after
        // the pipeline has been drained completely.
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
                drain();
            for (int n = 0; n < RANDOM_BEATS / 4; n++)
            begin
                while ($urandom_range(99) < idle_pct[phase])
                    rest();
                send_random();
            end
        end

        // Let the pipeline empty, then give it a little longer so a stray
        // extra strobe would still be caught.
        drain();
        repeat (PIPE_DEPTH + 8) rest();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Guard against a hung handshake. The limit below allows far more time than
    // a correct run needs.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/sfd_pkg.sv
rtl/sfd_front.sv
rtl/sfd_div_stage.sv
rtl/sfd_back.sv
rtl/saturating_fixed_divide_16_16.sv
tb/sv/sfd_quotient_checker.sv
tb/sv/testbench.sv
